// ===== rtl/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// Shared widths, default geometry and codes for the paged EEPROM mirror.
// ----------------------------------------------------------------------------
package pem_pkg;

   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 10;
   localparam int TOTAL_W  = 10;

   localparam int DEF_PAGE_SIZE        = 127;
   localparam int DEF_PAGE_COUNT       = 8;
   localparam int DEF_PAGE_SELECT_ADDR = 127;

   // dirty bitmap is held as words of DWORD_W bits
   localparam int DWORD_SH = 5;
   localparam int DWORD_W  = 1 << DWORD_SH;

   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PICK  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DONE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd4;

   typedef enum logic [2:0] {
      K_NONE,
      K_PAGE_SET,
      K_PAGE_READ,
      K_WRITE,
      K_READ,
      K_PICK,
      K_DONE,
      K_LOAD
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// ===== rtl/pem_req_if.sv =====
// ----------------------------------------------------------------------------
// pem_req_if
// Request channel: one bus access, flush or load word per handshake.
// ----------------------------------------------------------------------------
interface pem_req_if;
   import pem_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   addr;
   logic [BYTE_W-1:0]   data;
   logic [OFFSET_W-1:0] load_offset;

   modport source (output valid, action, addr, data, load_offset, input ready);
   modport sink   (input valid, action, addr, data, load_offset, output ready);
endinterface

// ===== rtl/pem_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pem_rsp_if
// Response channel: one result word per request.
// ----------------------------------------------------------------------------
interface pem_rsp_if;
   import pem_pkg::*;

   logic                valid;
   logic                ready;
   logic                status;
   logic [BYTE_W-1:0]   read_data;
   logic [OFFSET_W-1:0] flush_offset;
   logic [BYTE_W-1:0]   flush_data;
   logic [TOTAL_W-1:0]  dirty_total;

   modport source (output valid, status, read_data, flush_offset, flush_data, dirty_total,
                   input ready);
   modport sink   (input valid, status, read_data, flush_offset, flush_data, dirty_total,
                   output ready);
endinterface

// ===== rtl/pem_ram.sv =====
// ----------------------------------------------------------------------------
// pem_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/paged_eeprom_dirty_mirror.sv =====
// ----------------------------------------------------------------------------
// paged_eeprom_dirty_mirror
// RAM mirror of a paged EEPROM with a dirty bitmap and a write-back picker.
//
//   channel   direction  word contents
//   req_bus   in         action, addr, data, load_offset
//   rsp_bus   out        status, read_data, flush_offset, flush_data, dirty_total
//
// Each request passes through accept and decode, memory read, modify and
// write back, and result load, in order; the byte RAM and the dirty-word RAM
// have registered reads. A flush pick finds the lowest dirty word from a
// per-word summary register, then the lowest bit within the word read.
// Reset is synchronous; the summary register marks every dirty word empty,
// so no clearing pass runs. A held result stalls only the result load step.
// ----------------------------------------------------------------------------
module paged_eeprom_dirty_mirror #(
   parameter int PAGE_SIZE        = pem_pkg::DEF_PAGE_SIZE,
   parameter int PAGE_COUNT       = pem_pkg::DEF_PAGE_COUNT,
   parameter int PAGE_SELECT_ADDR = pem_pkg::DEF_PAGE_SELECT_ADDR
) (
   input  logic       clock,
   input  logic       reset,
   pem_req_if.sink    req_bus,
   pem_rsp_if.source  rsp_bus
);
   import pem_pkg::*;

   localparam int MIRROR_BYTES = PAGE_SIZE * PAGE_COUNT;
   localparam int MIR_AW = (MIRROR_BYTES > 1) ? $clog2(MIRROR_BYTES) : 1;
   localparam int DWORDS = (MIRROR_BYTES + DWORD_W - 1) / DWORD_W;
   localparam int WIDX_W = (DWORDS > 1) ? $clog2(DWORDS) : 1;
   localparam int DOFF_W = WIDX_W + DWORD_SH;
   localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int CNT_W  = $clog2(MIRROR_BYTES + 1);
   localparam int SUM_W  = $clog2(MIRROR_BYTES + 256);

   state_type               state_ff, state_in;
   kind_type                kind_ff, kind_in;
   logic [DOFF_W-1:0]       off_ff, off_in;
   logic [BYTE_W-1:0]       data_ff, data_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic                    inflight_valid_ff, inflight_valid_in;
   logic [DOFF_W-1:0]       inflight_off_ff, inflight_off_in;
   logic [DWORDS-1:0]       summary_ff, summary_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    status_ff, status_in;
   logic [BYTE_W-1:0]       rd_ff, rd_in;
   logic [OFFSET_W-1:0]     foff_ff, foff_in;
   logic [BYTE_W-1:0]       fdata_ff, fdata_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;

   logic                    accept;
   logic [SUM_W-1:0]        off_calc;
   logic                    addr_sel, addr_low, off_ok;
   logic [WIDX_W-1:0]       pick_word;
   logic [WIDX_W-1:0]       off_word;
   logic [DWORD_SH-1:0]     bit_sel, pick_bit;
   logic [DWORD_W-1:0]      dword, bit_mask, dword_new;
   logic                    bit_set;
   logic [DOFF_W-1:0]       pick_off;
   logic                    rsp_free;

   logic                    dmem_we, dmem_re;
   logic [DWORD_W-1:0]      dmem_rdata;
   logic                    mir_we, mir_re;
   logic [MIR_AW-1:0]       mir_raddr;
   logic [BYTE_W-1:0]       mir_rdata;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // decode
   assign off_calc = SUM_W'(page_ff) * SUM_W'(PAGE_SIZE) + SUM_W'(req_bus.addr);
   assign addr_sel = (req_bus.addr == BYTE_W'(PAGE_SELECT_ADDR));
   assign addr_low = (req_bus.addr < BYTE_W'(PAGE_SELECT_ADDR));
   assign off_ok   = (off_calc < SUM_W'(MIRROR_BYTES));

   always_comb begin
      pick_word = '0;
      for (int i = DWORDS - 1; i >= 0; i--) begin
         if (summary_ff[i]) begin
            pick_word = WIDX_W'(i);
         end
      end
   end

   // dirty word access
   assign off_word = off_ff[DOFF_W-1:DWORD_SH];
   assign bit_sel  = off_ff[DWORD_SH-1:0];
   assign dword    = summary_ff[off_word] ? dmem_rdata : '0;
   assign bit_mask = DWORD_W'(1) << bit_sel;
   assign bit_set  = |(dword & bit_mask);
   assign dword_new = (kind_ff == K_WRITE) ? (dword | bit_mask) : (dword & ~bit_mask);

   always_comb begin
      pick_bit = '0;
      for (int i = DWORD_W - 1; i >= 0; i--) begin
         if (dword[i]) begin
            pick_bit = DWORD_SH'(i);
         end
      end
   end

   assign pick_off = {off_word, pick_bit};

   assign dmem_re = (state_ff == ST_READ);
   assign dmem_we = (state_ff == ST_MODIFY) &&
                    (((kind_ff == K_WRITE) && !bit_set) ||
                     (((kind_ff == K_LOAD) || (kind_ff == K_DONE)) && bit_set));
   assign mir_we  = (state_ff == ST_MODIFY) && ((kind_ff == K_WRITE) || (kind_ff == K_LOAD));
   assign mir_re  = ((state_ff == ST_READ) && (kind_ff == K_READ)) ||
                    ((state_ff == ST_MODIFY) && (kind_ff == K_PICK));
   assign mir_raddr = (state_ff == ST_MODIFY) ? pick_off[MIR_AW-1:0] : off_ff[MIR_AW-1:0];

   always_comb begin
      state_in          = state_ff;
      kind_in           = kind_ff;
      off_in            = off_ff;
      data_in           = data_ff;
      page_in           = page_ff;
      inflight_valid_in = inflight_valid_ff;
      inflight_off_in   = inflight_off_ff;
      summary_in        = summary_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_bus.ready;
      status_in         = status_ff;
      rd_in             = rd_ff;
      foff_in           = foff_ff;
      fdata_in          = fdata_ff;
      total_in          = total_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = K_NONE;
               off_in   = DOFF_W'(off_calc);
               data_in  = req_bus.data;
               state_in = ST_READ;
               case (req_bus.action)
                  ACT_WRITE: begin
                     if (addr_sel) begin
                        if (32'(req_bus.data) < PAGE_COUNT) begin
                           kind_in = K_PAGE_SET;
                        end
                     end else if (addr_low && off_ok) begin
                        kind_in = K_WRITE;
                     end
                  end
                  ACT_READ: begin
                     if (addr_sel) begin
                        kind_in = K_PAGE_READ;
                     end else if (addr_low && off_ok) begin
                        kind_in = K_READ;
                     end
                  end
                  ACT_PICK: begin
                     if (!inflight_valid_ff && (summary_ff != '0)) begin
                        kind_in = K_PICK;
                        off_in  = {pick_word, DWORD_SH'(0)};
                     end
                  end
                  ACT_DONE: begin
                     if (inflight_valid_ff) begin
                        kind_in = K_DONE;
                        off_in  = inflight_off_ff;
                     end
                  end
                  ACT_LOAD: begin
                     if (32'(req_bus.load_offset) < MIRROR_BYTES) begin
                        kind_in = K_LOAD;
                        off_in  = DOFF_W'(req_bus.load_offset);
                     end
                  end
                  default: begin
                     kind_in = K_NONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            state_in = ST_FINISH;
            if (dmem_we) begin
               summary_in[off_word] = |dword_new;
               count_in = (kind_ff == K_WRITE) ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
            end
            case (kind_ff)
               K_PAGE_SET: begin
                  page_in = PAGE_W'(data_ff);
               end
               K_PICK: begin
                  off_in            = pick_off;
                  inflight_off_in   = pick_off;
                  inflight_valid_in = 1'b1;
               end
               K_DONE: begin
                  inflight_valid_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = (kind_ff == K_NONE);
               rd_in        = (kind_ff == K_READ) ? mir_rdata :
                              (kind_ff == K_PAGE_READ) ? BYTE_W'(page_ff) : '0;
               foff_in      = (kind_ff == K_PICK) ? OFFSET_W'(off_ff) : '0;
               fdata_in     = (kind_ff == K_PICK) ? mir_rdata : '0;
               total_in     = TOTAL_W'(count_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         kind_ff           <= K_NONE;
         page_ff           <= '0;
         inflight_valid_ff <= 1'b0;
         inflight_off_ff   <= '0;
         summary_ff        <= '0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         kind_ff           <= kind_in;
         page_ff           <= page_in;
         inflight_valid_ff <= inflight_valid_in;
         inflight_off_ff   <= inflight_off_in;
         summary_ff        <= summary_in;
         count_ff          <= count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      data_ff  <= data_in;
      status_ff <= status_in;
      rd_ff    <= rd_in;
      foff_ff  <= foff_in;
      fdata_ff <= fdata_in;
      total_ff <= total_in;
   end

   pem_ram #(
      .WIDTH (DWORD_W),
      .DEPTH (DWORDS)
   ) u_dirty_ram (
      .clock (clock),
      .we    (dmem_we),
      .waddr (off_word),
      .wdata (dword_new),
      .re    (dmem_re),
      .raddr (off_word),
      .rdata (dmem_rdata)
   );

   pem_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MIRROR_BYTES)
   ) u_mirror_ram (
      .clock (clock),
      .we    (mir_we),
      .waddr (off_ff[MIR_AW-1:0]),
      .wdata (data_ff),
      .re    (mir_re),
      .raddr (mir_raddr),
      .rdata (mir_rdata)
   );

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.read_data    = rd_ff;
   assign rsp_bus.flush_offset = foff_ff;
   assign rsp_bus.flush_data   = fdata_ff;
   assign rsp_bus.dirty_total  = total_ff;

   a_count_matches_summary: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) == (summary_ff != '0))
      else $error("dirty count disagrees with word summary");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MIRROR_BYTES))
      else $error("dirty count above mirror size");

   a_pick_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) && (kind_ff == K_PICK) |-> (dword != '0))
      else $error("flush pick landed on a clean word");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && rsp_free |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("result not loaded on finish");

   a_dirty_write_in_modify: assert property (@(posedge clock) disable iff (reset)
      (dmem_we || mir_we) |-> (state_ff == ST_MODIFY))
      else $error("memory write outside modify cycle");

endmodule

// ===== verif/tb_paged_eeprom_dirty_mirror.sv =====
// ----------------------------------------------------------------------------
// tb_paged_eeprom_dirty_mirror
// Self-checking bench for the paged EEPROM mirror. A directed run of page
// selects, bounds, flush and load corner cases is followed by random bus
// traffic and flush sequences over four handshake pressure phases. Each
// accepted request word is run through a local model of the mirror, dirty
// bitmap and in-flight entry, and every response word is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_paged_eeprom_dirty_mirror;
   timeunit 1ns;
   timeprecision 1ps;
   import pem_pkg::*;

   localparam int PSIZE      = DEF_PAGE_SIZE;
   localparam int PCOUNT     = DEF_PAGE_COUNT;
   localparam int PSEL       = DEF_PAGE_SELECT_ADDR;
   localparam int MIRROR_LEN = PSIZE * PCOUNT;
   localparam int BYTE_MAX   = (1 << BYTE_W) - 1;
   localparam int OFFSET_MAX = (1 << OFFSET_W) - 1;
   localparam int PHASE_ITEMS = 130;

   localparam logic [ACTION_W-1:0] ACT_BAD_LO = ACT_LOAD + 1'b1;
   localparam logic [ACTION_W-1:0] ACT_BAD_HI = '1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
      logic [OFFSET_W-1:0] load_offset;
   } req_word_type;

   typedef struct packed {
      logic                status;
      logic [BYTE_W-1:0]   read_data;
      logic [OFFSET_W-1:0] flush_offset;
      logic [BYTE_W-1:0]   flush_data;
      logic [TOTAL_W-1:0]  dirty_total;
   } rsp_word_type;

   logic clock;
   logic reset;

   pem_req_if req_ch ();
   pem_rsp_if rsp_ch ();

   paged_eeprom_dirty_mirror dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   req_word_type bus_words[$];
   rsp_word_type due_results[$];
   req_word_type held_word;
   int        fault_count = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;

   // mirror model
   logic [BYTE_W-1:0] mir_bytes [MIRROR_LEN];
   bit                dirty_map [MIRROR_LEN];
   int                dirty_count = 0;
   int                page_now = 0;
   int                flight_off = 0;
   bit                flight_busy = 1'b0;

   // stimulus-side tracking of the page and of written bytes
   bit gen_written [MIRROR_LEN];
   int gen_page = 0;
   int gen_count = 0;

   function automatic rsp_word_type mirror_step(input req_word_type w);
      rsp_word_type r;
      int a, d, lo, off, i;
      bit found;
      a = int'(w.addr);
      d = int'(w.data);
      lo = int'(w.load_offset);
      off = page_now * PSIZE + a;
      found = 1'b0;
      r = '0;
      r.status = 1'b1;
      case (w.action)
         ACT_WRITE: begin
            if (a == PSEL) begin
               if (d < PCOUNT) begin
                  page_now = d;
                  r.status = 1'b0;
               end
            end else if (a < PSEL && off < MIRROR_LEN) begin
               mir_bytes[off] = w.data;
               if (!dirty_map[off]) begin
                  dirty_map[off] = 1'b1;
                  dirty_count++;
               end
               r.status = 1'b0;
            end
         end
         ACT_READ: begin
            if (a == PSEL) begin
               r.read_data = BYTE_W'(page_now);
               r.status = 1'b0;
            end else if (a < PSEL && off < MIRROR_LEN) begin
               r.read_data = mir_bytes[off];
               r.status = 1'b0;
            end
         end
         ACT_PICK: begin
            if (!flight_busy && dirty_count > 0) begin
               for (i = 0; i < MIRROR_LEN && !found; i++) begin
                  if (dirty_map[i]) begin
                     found = 1'b1;
                     flight_off = i;
                     flight_busy = 1'b1;
                     r.flush_offset = OFFSET_W'(i);
                     r.flush_data = mir_bytes[i];
                     r.status = 1'b0;
                  end
               end
            end
         end
         ACT_DONE: begin
            if (flight_busy) begin
               if (flight_off < MIRROR_LEN && dirty_map[flight_off]) begin
                  dirty_map[flight_off] = 1'b0;
                  dirty_count--;
               end
               flight_busy = 1'b0;
               r.status = 1'b0;
            end
         end
         ACT_LOAD: begin
            if (lo < MIRROR_LEN) begin
               mir_bytes[lo] = w.data;
               if (dirty_map[lo]) begin
                  dirty_map[lo] = 1'b0;
                  dirty_count--;
               end
               r.status = 1'b0;
            end
         end
         default: ;
      endcase
      r.dirty_total = TOTAL_W'(dirty_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      fault_count++;
      if (fault_count <= 50)
         $display("ERROR %0t: %s", $realtime, what);
   endtask

   task automatic add_word(input logic [ACTION_W-1:0] act, input int a, input int d,
                           input int lo);
      req_word_type w;
      int off;
      w.action = act;
      w.addr = BYTE_W'(a);
      w.data = BYTE_W'(d);
      w.load_offset = OFFSET_W'(lo);
      bus_words.push_back(w);
      gen_count++;
      off = gen_page * PSIZE + a;
      if (act == ACT_WRITE && a == PSEL && d < PCOUNT)
         gen_page = d;
      else if (act == ACT_WRITE && a < PSEL && off < MIRROR_LEN)
         gen_written[off] = 1'b1;
      if (act == ACT_LOAD && lo < MIRROR_LEN)
         gen_written[lo] = 1'b1;
   endtask

   // pick an address in the current page whose byte holds data, else the page register
   function automatic int readable_addr();
      int a, k, off;
      for (k = 0; k < 8; k++) begin
         a = $urandom_range(PSEL - 1);
         off = gen_page * PSIZE + a;
         if (off < MIRROR_LEN && gen_written[off])
            return a;
      end
      return PSEL;
   endfunction

   task automatic add_random(input int target);
      int stop, c, k, n;
      stop = gen_count + target;
      while (gen_count < stop) begin
         c = $urandom_range(99);
         if (c < 30) begin
            add_word(ACT_WRITE, $urandom_range(PSEL - 1), $urandom_range(BYTE_MAX),
                     $urandom_range(OFFSET_MAX));
         end else if (c < 45) begin
            add_word(ACT_READ, readable_addr(), $urandom_range(BYTE_MAX),
                     $urandom_range(OFFSET_MAX));
         end else if (c < 53) begin
            k = ($urandom_range(7) == 0) ? $urandom_range(BYTE_MAX, PCOUNT)
                                         : $urandom_range(PCOUNT - 1);
            add_word(ACT_WRITE, PSEL, k, $urandom_range(OFFSET_MAX));
         end else if (c < 70) begin
            // flush sequence with traffic while the byte is in flight
            add_word(ACT_PICK, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                     $urandom_range(OFFSET_MAX));
            if ($urandom_range(1) == 1)
               add_word(ACT_WRITE, ($urandom_range(3) == 0) ? $urandom_range(7)
                                                            : $urandom_range(PSEL - 1),
                        $urandom_range(BYTE_MAX), $urandom_range(OFFSET_MAX));
            if ($urandom_range(3) == 0)
               add_word(ACT_LOAD, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                        $urandom_range(MIRROR_LEN - 1));
            add_word(ACT_DONE, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                     $urandom_range(OFFSET_MAX));
            if ($urandom_range(1) == 1)
               add_word(ACT_READ, readable_addr(), $urandom_range(BYTE_MAX),
                        $urandom_range(OFFSET_MAX));
         end else if (c < 80) begin
            n = $urandom_range(6, 1);
            for (k = 0; k < n; k++) begin
               add_word(ACT_PICK, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                        $urandom_range(OFFSET_MAX));
               add_word(ACT_DONE, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                        $urandom_range(OFFSET_MAX));
            end
         end else if (c < 90) begin
            k = ($urandom_range(7) == 0) ? $urandom_range(OFFSET_MAX, MIRROR_LEN)
                                         : $urandom_range(MIRROR_LEN - 1);
            add_word(ACT_LOAD, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX), k);
         end else begin
            case ($urandom_range(4))
               0: add_word(ACTION_W'($urandom_range(ACT_BAD_HI, ACT_BAD_LO)),
                           $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                           $urandom_range(OFFSET_MAX));
               1: add_word(ACT_WRITE, $urandom_range(BYTE_MAX, PSEL + 1),
                           $urandom_range(BYTE_MAX), $urandom_range(OFFSET_MAX));
               2: add_word(ACT_READ, $urandom_range(BYTE_MAX, PSEL + 1),
                           $urandom_range(BYTE_MAX), $urandom_range(OFFSET_MAX));
               3: add_word(ACT_PICK, $urandom_range(BYTE_MAX), $urandom_range(BYTE_MAX),
                           $urandom_range(OFFSET_MAX));
               default: add_word(ACT_DONE, $urandom_range(BYTE_MAX),
                                 $urandom_range(BYTE_MAX), $urandom_range(OFFSET_MAX));
            endcase
         end
      end
   endtask

   task automatic add_directed();
      int k;
      add_word(ACT_READ, PSEL, 0, 0);
      add_word(ACT_WRITE, 0, BYTE_MAX, OFFSET_MAX);
      add_word(ACT_WRITE, PSEL - 1, 0, 0);
      add_word(ACT_READ, 0, 0, 0);
      add_word(ACT_READ, PSEL - 1, BYTE_MAX, OFFSET_MAX);
      add_word(ACT_WRITE, PSEL, PCOUNT - 1, 0);
      add_word(ACT_WRITE, PSEL - 1, 'hA5, 0);
      add_word(ACT_READ, PSEL, 0, 0);
      add_word(ACT_WRITE, PSEL, PCOUNT, 0);
      add_word(ACT_WRITE, PSEL, BYTE_MAX, 0);
      add_word(ACT_WRITE, PSEL + 1, 'h3C, 0);
      add_word(ACT_READ, BYTE_MAX, 0, 0);
      add_word(ACT_LOAD, 0, 'h77, MIRROR_LEN);
      add_word(ACT_LOAD, 0, 'h77, OFFSET_MAX);
      add_word(ACT_PICK, 0, 0, 0);
      add_word(ACT_PICK, 0, 0, 0);
      add_word(ACT_WRITE, PSEL, 0, 0);
      add_word(ACT_WRITE, 0, 'h11, 0);
      add_word(ACT_DONE, 0, 0, 0);
      add_word(ACT_DONE, 0, 0, 0);
      add_word(ACT_LOAD, 0, 'h33, PSEL - 1);
      add_word(ACT_PICK, 0, 0, 0);
      add_word(ACT_LOAD, 0, 'hC3, MIRROR_LEN - 1);
      add_word(ACT_DONE, 0, 0, 0);
      add_word(ACT_PICK, 0, 0, 0);
      for (k = ACT_BAD_LO; k <= ACT_BAD_HI; k++)
         add_word(ACTION_W'(k), BYTE_MAX, BYTE_MAX, OFFSET_MAX);
   endtask

   task automatic wait_drained();
      while (bus_words.size() != 0 || req_ch.valid === 1'b1 || due_results.size() != 0)
         @(negedge clock);
   endtask

   always #1 clock = ~clock;

   // driver: advance to the next word on a handshake or an empty slot
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.action <= '0;
         req_ch.addr <= '0;
         req_ch.data <= '0;
         req_ch.load_offset <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid)
            due_results.push_back(mirror_step(held_word));
         if (bus_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            held_word = bus_words.pop_front();
            req_ch.action <= held_word.action;
            req_ch.addr <= held_word.addr;
            req_ch.data <= held_word.data;
            req_ch.load_offset <= held_word.load_offset;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               if (rsp_ch.status !== due_results[0].status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status,
                                            due_results[0].status));
               if (rsp_ch.read_data !== due_results[0].read_data)
                  report_mismatch($sformatf("read_data %0d, want %0d", rsp_ch.read_data,
                                            due_results[0].read_data));
               if (rsp_ch.flush_offset !== due_results[0].flush_offset)
                  report_mismatch($sformatf("flush_offset %0d, want %0d",
                                            rsp_ch.flush_offset,
                                            due_results[0].flush_offset));
               if (rsp_ch.flush_data !== due_results[0].flush_data)
                  report_mismatch($sformatf("flush_data %0d, want %0d", rsp_ch.flush_data,
                                            due_results[0].flush_data));
               if (rsp_ch.dirty_total !== due_results[0].dirty_total)
                  report_mismatch($sformatf("dirty_total %0d, want %0d",
                                            rsp_ch.dirty_total,
                                            due_results[0].dirty_total));
               void'(due_results.pop_front());
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #400000;
      $display("paged_eeprom_dirty_mirror: mismatch");
      $finish;
   end

   initial begin
      int send_tab [4];
      int recv_tab [4];
      int p;
      send_tab = '{0, 87, 0, 29};
      recv_tab = '{0, 0, 87, 29};
      clock = 1'b0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < 4; p++) begin
         @(negedge clock);
         send_idle_pct = send_tab[p];
         recv_stall_pct = recv_tab[p];
         if (p == 0)
            add_directed();
         add_random(PHASE_ITEMS);
         wait_drained();
      end
      repeat (16) @(negedge clock);
      if (fault_count == 0)
         $display("paged_eeprom_dirty_mirror: match");
      else
         $display("paged_eeprom_dirty_mirror: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pem_pkg.sv
rtl/pem_req_if.sv
rtl/pem_rsp_if.sv
rtl/pem_ram.sv
rtl/paged_eeprom_dirty_mirror.sv
verif/tb_paged_eeprom_dirty_mirror.sv
